// ===== design/gsl_pkg.sv =====
// Shared types and constants for the gas sensor linearizer.
// No dependencies; every other design file imports this package.
`default_nettype none

package gsl_pkg;

	// Number of sensor channels with their own calibration state.
	localparam int NUM_SENSORS = 8;

	// Fixed-point constants of the conversion.
	localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
	localparam logic [23:0] GAIN_RESET = 24'd4096;
	localparam logic [23:0] FULL_Q12   = 24'd16773120;
	localparam logic [23:0] GAIN_NUM   = 24'd16773120;
	localparam logic [13:0] R_SCALE    = 14'd10000;
	localparam logic [14:0] R_CAP      = 15'd25200;
	localparam logic [23:0] POW5_10    = 24'd9765625;
	localparam logic [13:0] PPM_LOW    = 14'd2;
	localparam logic [13:0] PPM_HIGH   = 14'd16000;
	localparam logic [28:0] F_ONE      = 29'd1048576;

	// Iterative divider: quotient bits produced, one per cycle.
	localparam int DIV_STEPS = 24;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TEMP_COEFF  = 2'd0,
		REG_REF_TEMP    = 2'd1,
		REG_CAL_SAMPLES = 2'd2
	} gsl_reg_t;

	typedef struct packed {
		logic [15:0] temp_coeff;
		logic [11:0] ref_temp;
		logic [6:0]  cal_samples;
	} gsl_cfg_t;

	typedef struct packed {
		logic        command;
		logic [2:0]  sensor;
		logic [11:0] sample;
		logic [11:0] temperature;
	} gsl_in_t;

	typedef struct packed {
		logic [23:0] ppm;
		logic [2:0]  sensor_out;
		logic        cal_done;
		logic        saturated;
	} gsl_out_t;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic        busy;
		logic        ovf;
		logic [23:0] quot;
	} gsl_div_stat_t;

endpackage

`default_nettype wire

// ===== design/gsl_cfg.sv =====
// APB-style configuration registers of the gas sensor linearizer.
// Depends on gsl_pkg for the register indexes and the configuration struct.
`default_nettype none

module gsl_cfg import gsl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output gsl_cfg_t         cfg
);

	gsl_cfg_t cfg_q;
	logic     wr_en;
	gsl_reg_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = gsl_reg_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_coeff  <= 16'd1311;
			cfg_q.ref_temp    <= 12'd400;
			cfg_q.cal_samples <= 7'd100;
		end else if (wr_en) begin
			case (idx)
				REG_TEMP_COEFF:  cfg_q.temp_coeff  <= pwdata[15:0];
				REG_REF_TEMP:    cfg_q.ref_temp    <= pwdata[11:0];
				REG_CAL_SAMPLES: cfg_q.cal_samples <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Read-back of the register values.
	always_comb begin
		case (idx)
			REG_TEMP_COEFF:  prdata = {16'd0, cfg_q.temp_coeff};
			REG_REF_TEMP:    prdata = {20'd0, cfg_q.ref_temp};
			REG_CAL_SAMPLES: prdata = {25'd0, cfg_q.cal_samples};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/gsl_mul.sv =====
// Shared 32 by 32 bit multiplier with a registered product.
// Depends on gsl_pkg only by convention; no package items used beyond import.
`default_nettype none

module gsl_mul import gsl_pkg::*; (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);

	logic [63:0] p_q;

	// One product per cycle, available in the following cycle.
	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

`default_nettype wire

// ===== design/gsl_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow detection.
// Depends on gsl_pkg for the step count and the status struct.
`default_nettype none

module gsl_div import gsl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] num,
	input  wire logic [23:0] den,
	output gsl_div_stat_t    stat
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [47:0]          rem_q;
	logic [47:0]          dsh_q;
	logic [23:0]          quot_q;
	logic                 ovf_q;
	logic                 ge;

	assign ge = rem_q >= dsh_q;

	// Step counter is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Datapath: compare and subtract the shifted divisor once a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= {1'b0, den, 23'd0};
			quot_q <= '0;
			ovf_q  <= num >= {den, 24'd0};
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[22:0], ge};
			dsh_q  <= {1'b0, dsh_q[47:1]};
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.ovf  = ovf_q;
	assign stat.quot = quot_q;

endmodule

`default_nettype wire

// ===== design/gas_sensor_linearizer.sv =====
// Gas sensor linearizer: top level with the sequencer, per-sensor state,
// the shared multiplier and divider. Depends on gsl_pkg, gsl_cfg, gsl_mul, gsl_div.
//
// Usage: one input word per sample on the item channel (valid/ready) carries
// a command, a sensor index, a 12-bit converter reading and a temperature.
// Each word produces exactly one result word on the result channel.
// A calibration word goes through the accumulate step and the output step, or,
// when it completes the gain update, also through the 24-step divider with its
// start, wait and gain write; a completed sum of zero skips the divider.
// A measurement word forms the scaled sample and the resistance division, then
// 64*r^5, then runs the 14-step fourth-root search with four multiplier passes
// and a compare per step, then the second gain pass and the compensation, and
// last loads the output register. It skips the division when the scaled sample
// is zero or at full scale, and the final multiplier pass and clipping step when
// the compensation factor is negative. Only one word is worked on at a time:
// item_ready is high only while the sequencer is idle, so the next word is
// taken once the sequencer has returned to idle after loading the result.
// The result sits in an output register; the next word is accepted while a
// finished result still waits, and the sequencer only holds at its last step
// if the previous result has not been taken by then.
// Reset clears the gains to 1.0, the calibration sums and counts to zero and
// loads the default configuration. The user writes APB only while idle; unchecked.
`default_nettype none

module gas_sensor_linearizer import gsl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire gsl_in_t     item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output gsl_out_t         result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_C0, ST_C1, ST_DWC, ST_CG,
		ST_M0, ST_M1, ST_M2, ST_DWM, ST_M3,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
		ST_S0, ST_S1, ST_S2, ST_S3, ST_S4,
		ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4,
		ST_FIN
	} state_t;

	gsl_cfg_t      cfg;
	gsl_div_stat_t div_stat;
	state_t        state_q;

	logic [23:0] gain_q    [NUM_SENSORS];
	logic [18:0] cal_sum_q [NUM_SENSORS];
	logic [6:0]  cal_cnt_q [NUM_SENSORS];

	logic [2:0]  sen_q;
	logic [11:0] smp_q;
	logic [11:0] temp_q;
	logic [23:0] den_q;
	logic [14:0] r_q;
	logic [59:0] r4_q;
	logic [55:0] lo_q;
	logic [79:0] t_q;
	logic [23:0] m2hi_q;
	logic [13:0] y_q;
	logic [3:0]  bit_q;
	logic [25:0] p_q;
	logic [27:0] uf_q;
	logic [33:0] hi_q;
	logic [23:0] res_ppm_q;
	logic        res_done_q;
	logic        res_sat_q;
	logic        result_valid_q;
	gsl_out_t    result_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic        div_start;
	logic [47:0] div_num;

	logic [23:0] gain_rd;
	logic [18:0] new_sum;
	logic [6:0]  new_cnt;
	logic [35:0] x_val;
	logic [13:0] cand;
	logic [13:0] y_clamp;
	logic [12:0] d_val;
	logic [11:0] d_abs;
	logic [15:0] c_abs;
	logic        f_neg;
	logic [28:0] f_val;
	logic [80:0] cand_full;
	logic [74:0] t_sum;
	logic [34:0] v_val;

	gsl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	gsl_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	gsl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (den_q),
		.stat  (div_stat)
	);

	// Per-sensor reads and the small helper values of each step.
	assign gain_rd   = gain_q[sen_q];
	assign new_sum   = cal_sum_q[sen_q] + 19'(smp_q);
	assign new_cnt   = cal_cnt_q[sen_q] + 7'd1;
	assign x_val     = prod[35:0];
	assign cand      = y_q | (14'd1 << bit_q);
	assign cand_full = {1'b0, prod[47:0], 32'd0} + 81'(lo_q);
	assign t_sum     = {prod[42:0], 32'd0} + 75'(lo_q);
	assign v_val     = 35'(hi_q) + 35'(prod[47:20]);

	always_comb begin
		if (y_q < PPM_LOW) begin
			y_clamp = PPM_LOW;
		end else if (y_q > PPM_HIGH) begin
			y_clamp = PPM_HIGH;
		end else begin
			y_clamp = y_q;
		end
	end

	// Temperature offset and coefficient as sign and magnitude.
	always_comb begin
		d_val = {temp_q[11], temp_q} - {cfg.ref_temp[11], cfg.ref_temp};
		d_abs = d_val[12] ? 12'(~d_val + 13'd1) : d_val[11:0];
		c_abs = cfg.temp_coeff[15] ? (~cfg.temp_coeff + 16'd1) : cfg.temp_coeff;
		f_neg = d_val[12] ^ cfg.temp_coeff[15];
		f_val = f_neg ? (F_ONE - {2'b00, prod[26:0]}) : (F_ONE + {2'b00, prod[26:0]});
	end

	// Operands of the shared multiplier and divider for each step.
	always_comb begin
		mul_a     = 32'd0;
		mul_b     = 32'd0;
		div_start = 1'b0;
		div_num   = prod[47:0];
		case (state_q)
			ST_C0: begin
				mul_a = 32'(new_cnt);
				mul_b = 32'(GAIN_NUM);
			end
			ST_C1: div_start = 1'b1;
			ST_M0: begin
				mul_a = 32'(smp_q);
				mul_b = 32'(gain_rd);
			end
			ST_M1: begin
				mul_a = 32'(FULL_Q12 - x_val[23:0]);
				mul_b = 32'(R_SCALE);
			end
			ST_M2: div_start = 1'b1;
			ST_P0: begin
				mul_a = 32'(r_q);
				mul_b = 32'(r_q);
			end
			ST_P1: begin
				mul_a = 32'(prod[29:0]);
				mul_b = 32'(prod[29:0]);
			end
			ST_P2: begin
				mul_a = prod[31:0];
				mul_b = 32'(r_q);
			end
			ST_P3: begin
				mul_a = 32'(r4_q[59:32]);
				mul_b = 32'(r_q);
			end
			ST_S0: begin
				mul_a = 32'(cand);
				mul_b = 32'(cand);
			end
			ST_S1: begin
				mul_a = 32'(prod[27:0]);
				mul_b = 32'(prod[27:0]);
			end
			ST_S2: begin
				mul_a = prod[31:0];
				mul_b = 32'(POW5_10);
			end
			ST_S3: begin
				mul_a = 32'(m2hi_q);
				mul_b = 32'(POW5_10);
			end
			ST_Q0: begin
				mul_a = 32'(y_clamp);
				mul_b = 32'(gain_rd);
			end
			ST_Q1: begin
				mul_a = 32'(d_abs);
				mul_b = 32'(c_abs);
			end
			ST_Q2: begin
				mul_a = 32'(p_q[25:20]);
				mul_b = 32'(f_val[27:0]);
			end
			ST_Q3: begin
				mul_a = 32'(p_q[19:0]);
				mul_b = 32'(uf_q);
			end
			default: ;
		endcase
	end

	assign item_ready   = state_q == ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Sequencer, per-sensor state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				gain_q[i]    <= GAIN_RESET;
				cal_sum_q[i] <= '0;
				cal_cnt_q[i] <= '0;
			end
		end else begin
			// The final step reloads the output register itself.
			if (result_valid_q && result_ready && state_q != ST_FIN) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						sen_q      <= item.sensor;
						smp_q      <= item.sample;
						temp_q     <= item.temperature;
						res_ppm_q  <= '0;
						res_done_q <= 1'b0;
						res_sat_q  <= 1'b0;
						if ({1'b0, item.sensor} >= 4'(NUM_SENSORS)) begin
							state_q <= ST_FIN;
						end else if (item.command) begin
							state_q <= ST_C0;
						end else begin
							state_q <= ST_M0;
						end
					end
				end
				// Calibration: accumulate, and on the last sample divide (a zero sum saturates the gain).
				ST_C0: begin
					if (new_cnt >= cfg.cal_samples) begin
						cal_sum_q[sen_q] <= '0;
						cal_cnt_q[sen_q] <= '0;
						res_done_q       <= 1'b1;
						den_q            <= 24'(new_sum);
						if (new_sum == '0) begin
							gain_q[sen_q] <= GAIN_MAX;
							state_q       <= ST_FIN;
						end else begin
							state_q <= ST_C1;
						end
					end else begin
						cal_sum_q[sen_q] <= new_sum;
						cal_cnt_q[sen_q] <= new_cnt;
						state_q          <= ST_FIN;
					end
				end
				ST_C1: state_q <= ST_DWC;
				ST_DWC: begin
					if (!div_stat.busy) begin
						state_q <= ST_CG;
					end
				end
				ST_CG: begin
					gain_q[sen_q] <= div_stat.ovf ? GAIN_MAX : div_stat.quot;
					state_q       <= ST_FIN;
				end
				// Measurement: scaled sample and load resistance.
				ST_M0: state_q <= ST_M1;
				ST_M1: begin
					den_q <= x_val[23:0];
					if (x_val == '0) begin
						r_q     <= R_CAP;
						state_q <= ST_P0;
					end else if (x_val >= 36'(FULL_Q12)) begin
						r_q     <= 15'd1;
						state_q <= ST_P0;
					end else begin
						state_q <= ST_M2;
					end
				end
				ST_M2: state_q <= ST_DWM;
				ST_DWM: begin
					if (!div_stat.busy) begin
						state_q <= ST_M3;
					end
				end
				ST_M3: begin
					if (div_stat.ovf || div_stat.quot > 24'(R_CAP)) begin
						r_q <= R_CAP;
					end else if (div_stat.quot == '0) begin
						r_q <= 15'd1;
					end else begin
						r_q <= div_stat.quot[14:0];
					end
					state_q <= ST_P0;
				end
				// Power law target: 64 * r^5.
				ST_P0: state_q <= ST_P1;
				ST_P1: state_q <= ST_P2;
				ST_P2: begin
					r4_q    <= prod[59:0];
					state_q <= ST_P3;
				end
				ST_P3: begin
					lo_q    <= 56'(prod[46:0]);
					state_q <= ST_P4;
				end
				ST_P4: begin
					t_q     <= {t_sum[73:0], 6'd0};
					y_q     <= '0;
					bit_q   <= 4'd13;
					state_q <= ST_S0;
				end
				// Fourth-root search: keep a bit while cand^4 * 5^10 fits.
				ST_S0: state_q <= ST_S1;
				ST_S1: state_q <= ST_S2;
				ST_S2: begin
					m2hi_q  <= prod[55:32];
					state_q <= ST_S3;
				end
				ST_S3: begin
					lo_q    <= prod[55:0];
					state_q <= ST_S4;
				end
				ST_S4: begin
					if (cand_full <= {1'b0, t_q}) begin
						y_q <= cand;
					end
					if (bit_q == '0) begin
						state_q <= ST_Q0;
					end else begin
						bit_q   <= bit_q - 4'd1;
						state_q <= ST_S0;
					end
				end
				// Second gain pass and temperature compensation.
				ST_Q0: state_q <= ST_Q1;
				ST_Q1: begin
					p_q     <= prod[37:12];
					state_q <= ST_Q2;
				end
				ST_Q2: begin
					uf_q <= f_val[27:0];
					if (f_val[28]) begin
						res_sat_q <= p_q != '0;
						state_q   <= ST_FIN;
					end else begin
						state_q <= ST_Q3;
					end
				end
				ST_Q3: begin
					hi_q    <= prod[33:0];
					state_q <= ST_Q4;
				end
				ST_Q4: begin
					if (v_val > 35'(GAIN_MAX)) begin
						res_ppm_q <= GAIN_MAX;
						res_sat_q <= 1'b1;
					end else begin
						res_ppm_q <= v_val[23:0];
					end
					state_q <= ST_FIN;
				end
				// Hand the word to the output register once it is free.
				ST_FIN: begin
					if (!result_valid_q || result_ready) begin
						result_q.ppm        <= res_ppm_q;
						result_q.sensor_out <= sen_q;
						result_q.cal_done   <= res_done_q;
						result_q.saturated  <= res_sat_q;
						result_valid_q      <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The divider is only started when it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// A calibration result never carries a concentration.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.cal_done) |-> (result.ppm == '0 && !result.saturated))
		else $error("calibration result with non-zero ppm");

	// No new word is taken while the divider is still working.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !div_stat.busy)
		else $error("ready while divider busy");

	// A result is loaded only from the final step of the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside final step");

endmodule

`default_nettype wire

// ===== tb/tb_gas_sensor_linearizer.sv =====
// Self-checking testbench for gas_sensor_linearizer: directed table, then random phases.
// Depends on gsl_pkg and the design; results are checked against an in-bench predictor.
`timescale 1ns / 100ps

module tb_gas_sensor_linearizer;
	import gsl_pkg::*;

	typedef struct {
		logic [15:0] coeff;
		logic [11:0] reft;
		logic [6:0]  ncal;
	} cfg_set_t;

	typedef struct {
		int       set;
		gsl_in_t  w;
		bit       typed;
		gsl_out_t res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	gsl_in_t     item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	gsl_out_t    result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Typed expectation travelling alongside the word on the item channel.
	bit          word_typed = 1'b0;
	gsl_out_t    word_res = '0;

	// Predictor state and configuration copy.
	logic signed [15:0] mdl_coeff;
	logic signed [11:0] mdl_ref;
	logic [6:0]         mdl_ncal;
	logic [23:0]        mdl_gain [NUM_SENSORS];
	logic [18:0]        mdl_sum [NUM_SENSORS];
	logic [6:0]         mdl_count [NUM_SENSORS];

	gsl_out_t    pending_results [$];
	bit          failed = 1'b0;
	int          stall_left = 0;
	int          stall_pct = 20;
	bit          gaps_on = 1'b1;
	cfg_set_t    cfg_sets [4];
	row_t        rows [$];

	gas_sensor_linearizer uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Integer square root, floor, by building the result bit by bit.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// Concentration in 1/16 ppm: floor of the fourth root of 64*r^5/5^10, clamped.
	function automatic longint unsigned conc_from_res(longint unsigned r);
		longint unsigned q;
		longint unsigned rem;
		longint unsigned t;
		longint unsigned y;
		q = (64 * r) / 64'd9765625;
		rem = (64 * r) % 64'd9765625;
		for (int i = 0; i < 4; i++) begin
			t = rem * r;
			q = q * r + t / 64'd9765625;
			rem = t % 64'd9765625;
		end
		y = int_sqrt(int_sqrt(q));
		if (y > 16000) y = 16000;
		if (y < 2) y = 2;
		return y;
	endfunction

	// Works out the result of one word and advances the per-sensor state.
	function automatic gsl_out_t linearize(gsl_in_t w);
		gsl_out_t o;
		int s;
		longint unsigned x;
		longint unsigned r;
		longint unsigned p;
		longint unsigned g;
		longint signed f;
		longint signed v;
		o = '0;
		s = int'(w.sensor);
		o.sensor_out = w.sensor;
		if (w.command) begin
			mdl_sum[s] = mdl_sum[s] + 19'(w.sample);
			mdl_count[s] = mdl_count[s] + 7'd1;
			if (mdl_count[s] >= mdl_ncal) begin
				if (mdl_sum[s] == 0)
					g = 64'hFFFFFF;
				else
					g = (64'd4095 * mdl_count[s] * 64'd4096) / mdl_sum[s];
				if (g > 64'hFFFFFF) g = 64'hFFFFFF;
				mdl_gain[s] = g[23:0];
				mdl_sum[s] = '0;
				mdl_count[s] = '0;
				o.cal_done = 1'b1;
			end
		end else begin
			x = 64'(w.sample) * 64'(mdl_gain[s]);
			if (x == 0)
				r = 25200;
			else if (x >= 64'd16773120)
				r = 1;
			else begin
				r = (64'd10000 * (64'd16773120 - x)) / x;
				if (r < 1) r = 1;
				if (r > 25200) r = 25200;
			end
			p = (conc_from_res(r) * 64'(mdl_gain[s])) >> 12;
			f = 64'sd1048576 + (longint'($signed(w.temperature)) - longint'(mdl_ref))
				* longint'(mdl_coeff);
			if (f < 0) begin
				o.saturated = (p != 0);
			end else begin
				v = (longint'(p) * f) >>> 20;
				if (v > 64'sd16777215) begin
					o.ppm = 24'hFFFFFF;
					o.saturated = 1'b1;
				end else
					o.ppm = v[23:0];
			end
		end
		return o;
	endfunction

	// Word accepted: record what it should produce. Result taken: check it.
	always @(posedge clk) begin
		gsl_out_t e;
		gsl_out_t p;
		if (item_valid && item_ready) begin
			p = linearize(item);
			pending_results.push_back(word_typed ? word_res : p);
		end
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: ppm %0d", result.ppm);
				failed = 1'b1;
			end else begin
				e = pending_results.pop_front();
				if (result.ppm !== e.ppm) begin
					$error("ppm: expected %0d, got %0d", e.ppm, result.ppm);
					failed = 1'b1;
				end
				if (result.sensor_out !== e.sensor_out) begin
					$error("sensor_out: expected %0d, got %0d", e.sensor_out, result.sensor_out);
					failed = 1'b1;
				end
				if (result.cal_done !== e.cal_done) begin
					$error("cal_done: expected %0d, got %0d", e.cal_done, result.cal_done);
					failed = 1'b1;
				end
				if (result.saturated !== e.saturated) begin
					$error("saturated: expected %0d, got %0d", e.saturated, result.saturated);
					failed = 1'b1;
				end
			end
		end
	end

	// Receiver back-pressure: short random stalls with the odd long one.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 99) == 0) begin
			stall_left <= int'($urandom_range(20, 60));
			result_ready <= 1'b0;
		end else
			result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// One register write over APB: setup cycle, then access cycle.
	task automatic apb_write(gsl_reg_t idx, logic [31:0] val);
		paddr <= {idx, 2'b00};
		pwdata <= val;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_config(cfg_set_t c);
		apb_write(REG_TEMP_COEFF, {16'd0, c.coeff});
		apb_write(REG_REF_TEMP, {20'd0, c.reft});
		apb_write(REG_CAL_SAMPLES, {25'd0, c.ncal});
		mdl_coeff = c.coeff;
		mdl_ref = c.reft;
		mdl_ncal = c.ncal;
	endtask

	// Let every outstanding result arrive, then settle.
	task automatic drain;
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Offer one word after an optional gap and wait until it is taken.
	task automatic send_word(gsl_in_t w, bit typed, gsl_out_t res);
		int gap;
		int k;
		gap = 0;
		k = int'($urandom_range(0, 9));
		if (gaps_on)
			gap = (k < 6) ? 0 : (k < 9) ? int'($urandom_range(1, 3))
				: int'($urandom_range(10, 40));
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		word_typed <= typed;
		word_res <= res;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	function automatic gsl_out_t out_word(int ppm, int s, bit done, bit sat);
		gsl_out_t o;
		o.ppm = 24'(ppm);
		o.sensor_out = 3'(s);
		o.cal_done = done;
		o.saturated = sat;
		return o;
	endfunction

	function automatic void add_row(int set, bit cmd, int s, int smp, int temp,
			bit typed, gsl_out_t res);
		row_t r;
		r.set = set;
		r.w.command = cmd;
		r.w.sensor = 3'(s);
		r.w.sample = 12'(smp);
		r.w.temperature = 12'(temp);
		r.typed = typed;
		r.res = res;
		rows.push_back(r);
	endfunction

	function automatic gsl_in_t random_word(int cal_pct, int smax);
		gsl_in_t w;
		w.command = ($urandom_range(0, 99) < cal_pct);
		w.sensor = 3'($urandom_range(0, smax));
		case ($urandom_range(0, 3))
			0: w.sample = 12'($urandom);
			1: w.sample = 12'($urandom_range(0, 15));
			2: w.sample = 12'($urandom_range(4000, 4095));
			default: w.sample = 12'($urandom_range(1000, 3000));
		endcase
		if ($urandom_range(0, 1))
			w.temperature = 12'($urandom);
		else
			w.temperature = 12'(int'($urandom_range(0, 2640)) - 640);
		return w;
	endfunction

	// Main sequence: reset, directed table, random phases, final check.
	initial begin
		int cur_set;
		int n;
		int cal_pct;
		int smax;
		cfg_set_t c;
		gsl_out_t none;
		none = '0;
		mdl_coeff = 16'sd1311;
		mdl_ref = 12'sd400;
		mdl_ncal = 7'd100;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			mdl_gain[i] = 24'd4096;
			mdl_sum[i] = '0;
			mdl_count[i] = '0;
		end
		cfg_sets[0] = '{16'd1311, 12'd400, 7'd100};
		cfg_sets[1] = '{16'hFC00, 12'd400, 7'd1};
		cfg_sets[2] = '{16'h7FFF, 12'hD80, 7'd0};
		cfg_sets[3] = '{16'h8000, 12'd2000, 7'd127};

		// Defaults: zero sample, full scale, negative factor, calibration below count.
		add_row(0, 0, 0, 0, 400, 1, out_word(16000, 0, 0, 0));
		add_row(0, 0, 1, 4095, 400, 1, out_word(2, 1, 0, 0));
		add_row(0, 0, 2, 2048, 400, 0, none);
		add_row(0, 0, 0, 1, -640, 1, out_word(0, 0, 0, 1));
		add_row(0, 0, 7, 4095, 2000, 0, none);
		add_row(0, 0, 4, 12'hAAA, 12'h555, 0, none);
		add_row(0, 1, 6, 4095, 0, 1, out_word(0, 6, 0, 0));
		add_row(0, 1, 6, 0, 0, 1, out_word(0, 6, 0, 0));
		// One-sample calibration: zero sum saturates the gain; zero factor.
		add_row(1, 1, 3, 0, 0, 1, out_word(0, 3, 1, 0));
		add_row(1, 0, 3, 0, 1424, 1, out_word(0, 3, 0, 0));
		add_row(1, 0, 3, 4095, 400, 1, out_word(8191, 3, 0, 0));
		add_row(1, 1, 6, 100, 0, 1, out_word(0, 6, 1, 0));
		// Largest coefficient: output clips at maximum; count of zero completes at once.
		add_row(2, 0, 3, 0, 2000, 1, out_word(24'hFFFFFF, 3, 0, 1));
		add_row(2, 1, 5, 2000, 0, 1, out_word(0, 5, 1, 0));
		add_row(2, 0, 5, 1000, -640, 0, none);
		add_row(2, 0, 6, 12'h555, 12'hAAA, 0, none);
		// Most negative coefficient, largest count.
		add_row(3, 0, 5, 3000, -640, 0, none);
		add_row(3, 0, 0, 100, 2000, 0, none);
		add_row(3, 1, 1, 4095, 0, 1, out_word(0, 1, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = 0;
		foreach (rows[i]) begin
			if (rows[i].set != cur_set) begin
				drain();
				cur_set = rows[i].set;
				load_config(cfg_sets[cur_set]);
			end
			send_word(rows[i].w, rows[i].typed, rows[i].res);
		end

		// Random phases, each under its own configuration.
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			c.coeff = 16'($urandom);
			c.reft = 12'($urandom);
			c.ncal = 7'($urandom_range(1, 6));
			n = 50;
			cal_pct = 40;
			smax = 7;
			gaps_on = (ph != 2);
			stall_pct = (ph == 4) ? 0 : (ph == 5) ? 60 : 20;
			if (ph == 0) begin
				// Long calibration run on one sensor so the largest count completes.
				c.ncal = 7'd127;
				n = 150;
				cal_pct = 90;
				smax = 0;
			end else if (ph == 1)
				c.coeff = 16'h0000;
			else if (ph == 3)
				c.ncal = 7'd0;
			load_config(c);
			for (int i = 0; i < n; i++) begin
				send_word(random_word(cal_pct, smax), 1'b0, none);
				if (ph == 6 && i == 30)
					drain();
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard limit on the run length.
	initial begin
		#(8_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/gsl_pkg.sv
design/gsl_cfg.sv
design/gsl_mul.sv
design/gsl_div.sv
design/gas_sensor_linearizer.sv
tb/tb_gas_sensor_linearizer.sv
